/* design/ggc_pkg.sv */
// Shared types, widths and constants for the go-to-goal controller.
// No dependencies; imported by ggc_sermul and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ggc_pkg;

  localparam int unsigned CORDIC_ITER_DEF = 16;
  localparam int unsigned ATAN_ENTRIES    = 24;
  localparam int unsigned IT_W            = 5;

  // CORDIC datapath widths
  localparam int unsigned XY_W  = 36;
  localparam int unsigned Z_W   = 20;
  localparam int unsigned ERR_W = 22;
  localparam int unsigned E13_W = 19;
  localparam int unsigned DIST_W = 34;

  // serial multiplier: signed A times unsigned 16-bit B
  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = 52;
  localparam int unsigned MUL_C_W = 4;

  localparam logic signed [ERR_W-1:0] ANG_PI      = 22'sd205887;
  localparam logic signed [ERR_W-1:0] ANG_TWO_PI  = 22'sd411775;
  localparam logic signed [Z_W-1:0]   ANG_HALF_PI = 20'sd102944;
  localparam logic [MUL_B_W-1:0]      INV_GAIN    = 16'd39797;

  // configuration register indexes
  localparam logic [2:0] CFG_GOAL_TOL   = 3'd0;
  localparam logic [2:0] CFG_MAX_LIN    = 3'd1;
  localparam logic [2:0] CFG_MAX_TURN   = 3'd2;
  localparam logic [2:0] CFG_TURN_THR   = 3'd3;
  localparam logic [2:0] CFG_TURN_GAIN  = 3'd4;
  localparam logic [2:0] CFG_STEER_GAIN = 3'd5;
  localparam logic [2:0] CFG_SPEED_GAIN = 3'd6;

  localparam logic CMD_GOAL = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [15:0] heading;
  } ggc_in_t;

  typedef struct packed {
    logic [22:0]        linear_speed;
    logic signed [23:0] turn_rate;
    logic               arrived;
    logic               goal_active;
  } ggc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MDIST,
    ST_WDIST,
    ST_DECIDE,
    ST_MLIN,
    ST_WLIN,
    ST_MRATE,
    ST_WRATE,
    ST_FINISH
  } ggc_state_e;

  // round(atan(2^-i) * 65536)
  function automatic logic [15:0] atan_q16(input logic [IT_W-1:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/unicycle_go_to_goal_controller.sv */
// Go-to-goal proportional controller: iterative CORDIC plus serial multiplier.
// Depends on ggc_pkg and ggc_sermul.
//
//   channel | direction | handshake              | payload
//   in      | in        | in_valid_i / in_stall_o  | ggc_in_t
//   out     | out       | out_valid_o / out_stall_i| ggc_out_t
//   cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Goal request: stored, no result. Tick without goal: a result that holds zeros.
// Tick with goal: CORDIC iterations, then the distance, linear-speed and rate
// products from the serial multiplier; an arrival skips the last two products
// and a turn in place skips the linear-speed product.
// Reset clears the goal and loads the register defaults.
// A waiting result holds in the output register; the core stalls only in its
// final step until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

module unicycle_go_to_goal_controller #(
  parameter int unsigned CORDIC_ITERATIONS = ggc_pkg::CORDIC_ITER_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ggc_pkg::ggc_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ggc_pkg::ggc_out_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);
  import ggc_pkg::*;

  // configuration
  logic [30:0] tol_q;
  logic [22:0] max_lin_q, max_turn_q;
  logic [14:0] thr_q;
  logic [15:0] turn_gain_q, steer_gain_q, speed_gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q        <= 31'd9830;
      max_lin_q    <= 23'd32768;
      max_turn_q   <= 23'd65536;
      thr_q        <= 15'd2458;
      turn_gain_q  <= 16'd12288;
      steer_gain_q <= 16'd8192;
      speed_gain_q <= 16'd3277;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GOAL_TOL:   tol_q        <= cfg_data_i[30:0];
        CFG_MAX_LIN:    max_lin_q    <= cfg_data_i[22:0];
        CFG_MAX_TURN:   max_turn_q   <= cfg_data_i[22:0];
        CFG_TURN_THR:   thr_q        <= cfg_data_i[14:0];
        CFG_TURN_GAIN:  turn_gain_q  <= cfg_data_i[15:0];
        CFG_STEER_GAIN: steer_gain_q <= cfg_data_i[15:0];
        CFG_SPEED_GAIN: speed_gain_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ggc_state_e state_q, state_d;

  logic                     in_acc, out_free;
  logic                     pend_q;
  logic signed [31:0]       goal_x_q, goal_y_q;
  logic signed [15:0]       hd_q;
  logic signed [XY_W-1:0]   x_q, y_q, x_d, y_d, x_init, y_init;
  logic signed [Z_W-1:0]    z_q, z_d, z_init;
  logic [IT_W-1:0]          it_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [E13_W-1:0]  e13_q, e13;
  logic [22:0]              lin_q, lin_sat;
  logic signed [23:0]       rate_q, rate_sat;
  logic                     arrived_q, active_q, turn_q;
  ggc_out_t                 out_q;
  logic                     out_valid_q;

  logic                     mul_start, mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic                     last_iter, arrive, turn;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_iter  = (it_q == IT_W'(CORDIC_ITERATIONS - 1));

  // goal minus pose, rotated into the right half plane
  logic signed [32:0] dx, dy;
  logic signed [XY_W-1:0] dx_e, dy_e;
  always_comb begin
    dx   = {goal_x_q[31], goal_x_q} - {in_data_i.point_x[31], in_data_i.point_x};
    dy   = {goal_y_q[31], goal_y_q} - {in_data_i.point_y[31], in_data_i.point_y};
    dx_e = XY_W'(dx);
    dy_e = XY_W'(dy);
    x_init = dx_e;
    y_init = dy_e;
    z_init = '0;
    if (dx[32]) begin
      if (!dy[32]) begin
        x_init = dy_e;
        y_init = -dx_e;
        z_init = ANG_HALF_PI;
      end else begin
        x_init = -dy_e;
        y_init = dx_e;
        z_init = -ANG_HALF_PI;
      end
    end
  end

  // one CORDIC micro-rotation per cycle
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  at;
  always_comb begin
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    at = $signed(Z_W'(atan_q16(it_q)));
    if (!y_q[XY_W-1]) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end
  end

  // heading error, wrapped and rounded to Q3.13
  logic signed [ERR_W-1:0] err0, errw, errr;
  logic signed [E13_W-1:0] thr_s;
  always_comb begin
    err0 = ERR_W'(z_q) - ERR_W'($signed({hd_q, 3'b000}));
    if (err0 > ANG_PI) begin
      errw = err0 - ANG_TWO_PI;
    end else if (err0 < -ANG_PI) begin
      errw = err0 + ANG_TWO_PI;
    end else begin
      errw = err0;
    end
    errr   = errw + ERR_W'(4);
    e13    = errr[ERR_W-1:3];
    thr_s  = $signed(E13_W'(thr_q));
    turn   = (e13 > thr_s) || (-e13 > thr_s);
    arrive = (dist_q < DIST_W'(tol_q));
  end

  // clamps on multiplier results
  logic [37:0]        lin_full;
  logic signed [42:0] rate_full, max_t;
  always_comb begin
    lin_full  = mul_p[49:12];
    lin_sat   = (lin_full > 38'(max_lin_q)) ? max_lin_q : lin_full[22:0];
    rate_full = mul_p[MUL_P_W-1:9];
    max_t     = $signed(43'(max_turn_q));
    if (rate_full > max_t) begin
      rate_sat = 24'(max_t);
    end else if (rate_full < -max_t) begin
      rate_sat = 24'(-max_t);
    end else begin
      rate_sat = rate_full[23:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.command == CMD_TICK) begin
          state_d = pend_q ? ST_CORDIC : ST_FINISH;
        end
      end
      ST_CORDIC: if (last_iter) state_d = ST_MDIST;
      ST_MDIST:  state_d = ST_WDIST;
      ST_WDIST:  if (mul_done) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (arrive) begin
          state_d = ST_FINISH;
        end else if (turn) begin
          state_d = ST_MRATE;
        end else begin
          state_d = ST_MLIN;
        end
      end
      ST_MLIN:   state_d = ST_WLIN;
      ST_WLIN:   if (mul_done) state_d = ST_MRATE;
      ST_MRATE:  state_d = ST_WRATE;
      ST_WRATE:  if (mul_done) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      ST_MDIST: begin
        mul_start = 1'b1;
        mul_a     = x_q;
        mul_b     = INV_GAIN;
      end
      ST_MLIN: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(dist_q);
        mul_b     = speed_gain_q;
      end
      ST_MRATE: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(e13_q);
        mul_b     = turn_q ? turn_gain_q : steer_gain_q;
      end
      default: ;
    endcase
  end

  ggc_sermul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && in_data_i.command == CMD_GOAL) begin
        goal_x_q <= in_data_i.point_x;
        goal_y_q <= in_data_i.point_y;
        pend_q   <= 1'b1;
      end else if (state_q == ST_DECIDE && arrive) begin
        pend_q <= 1'b0;
      end
      if (state_q == ST_CORDIC) begin
        it_q <= it_q + 1'b1;
      end else begin
        it_q <= '0;
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q       <= x_init;
        y_q       <= y_init;
        z_q       <= z_init;
        hd_q      <= in_data_i.heading;
        lin_q     <= '0;
        rate_q    <= '0;
        arrived_q <= 1'b0;
        active_q  <= 1'b0;
      end
      ST_CORDIC: begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
      end
      ST_WDIST: if (mul_done) dist_q <= mul_p[49:16];
      ST_DECIDE: begin
        e13_q     <= e13;
        turn_q    <= turn;
        arrived_q <= arrive;
        active_q  <= !arrive;
      end
      ST_WLIN:  if (mul_done) lin_q <= lin_sat;
      ST_WRATE: if (mul_done) rate_q <= rate_sat;
      ST_FINISH: begin
        if (out_free) begin
          out_q.linear_speed <= lin_q;
          out_q.turn_rate    <= rate_q;
          out_q.arrived      <= arrived_q;
          out_q.goal_active  <= active_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_arrive_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.arrived && out_data_o.goal_active))
    else $error("arrival reported with goal still active");

  a_stop_on_arrive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.arrived) |->
      (out_data_o.linear_speed == '0 && out_data_o.turn_rate == '0))
    else $error("nonzero speed on arrival");

  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_WDIST || state_q == ST_WLIN || state_q == ST_WRATE))
    else $error("multiplier finished outside a wait state");

  a_finish_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (out_valid_o && state_q == ST_IDLE))
    else $error("result not loaded on finish");

endmodule

`default_nettype wire

/* design/ggc_sermul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ggc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ggc_sermul (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [ggc_pkg::MUL_A_W-1:0] a_i,
  input  wire logic [ggc_pkg::MUL_B_W-1:0]      b_i,
  output logic                                  done_o,
  output logic signed [ggc_pkg::MUL_P_W-1:0]    p_o
);
  import ggc_pkg::*;

  logic signed [MUL_P_W-1:0] a_q, a_d, acc_q, acc_d;
  logic [MUL_B_W-1:0]        b_q, b_d;
  logic [MUL_C_W-1:0]        cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = MUL_P_W'(a_i);
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MUL_C_W'(MUL_B_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the go-to-goal controller: directed and random requests,
// each result checked against an in-bench fixed-point controller model.
// Depends on ggc_pkg and the unicycle_go_to_goal_controller RTL.
`timescale 1ns / 1ps

module tb_top;
  import ggc_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam longint CTL_PI = 205887;
  localparam longint CTL_TWO_PI = 411775;
  localparam longint CTL_HALF_PI = 102944;
  localparam longint CTL_INV_GAIN = 39797;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ggc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ggc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  unicycle_go_to_goal_controller dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // controller model state
  longint tol_r, max_lin_r, max_turn_r, thr_r, turn_gain_r, steer_gain_r, speed_gain_r;
  bit goal_held;
  longint goal_x_r, goal_y_r;
  longint atan_tbl [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};

  ggc_out_t expected_cmds[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic signed [31:0] last_goal_x = 0, last_goal_y = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit predict_command(input ggc_in_t req, output ggc_out_t resp);
    longint x, y, z, t, xs, ys, range_m, err, e13, rate, lin;
    resp = '0;
    if (req.command == CMD_GOAL) begin
      goal_x_r = req.point_x;
      goal_y_r = req.point_y;
      goal_held = 1'b1;
      return 1'b0;
    end
    if (!goal_held) return 1'b1;
    x = goal_x_r - longint'(req.point_x);
    y = goal_y_r - longint'(req.point_y);
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = CTL_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -CTL_HALF_PI;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tbl[i];
      end else begin
        x -= ys; y += xs; z -= atan_tbl[i];
      end
    end
    range_m = (x * CTL_INV_GAIN) >>> 16;
    if (range_m < tol_r) begin
      goal_held = 1'b0;
      resp.arrived = 1'b1;
      return 1'b1;
    end
    err = z - longint'(req.heading) * 8;
    while (err > CTL_PI) err -= CTL_TWO_PI;
    while (err < -CTL_PI) err += CTL_TWO_PI;
    e13 = (err + 4) >>> 3;
    if (e13 > thr_r || -e13 > thr_r) begin
      lin = 0;
      rate = (turn_gain_r * e13) >>> 9;
    end else begin
      lin = (speed_gain_r * range_m) >>> 12;
      if (lin > max_lin_r) lin = max_lin_r;
      rate = (steer_gain_r * e13) >>> 9;
    end
    if (rate > max_turn_r) rate = max_turn_r;
    if (rate < -max_turn_r) rate = -max_turn_r;
    resp.linear_speed = lin[22:0];
    resp.turn_rate = rate[23:0];
    resp.goal_active = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_req(input logic cmd, input logic signed [31:0] px,
                          input logic signed [31:0] py, input logic signed [15:0] hd);
    ggc_in_t req;
    ggc_out_t resp;
    req.command = cmd;
    req.point_x = px;
    req.point_y = py;
    req.heading = hd;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    if (predict_command(req, resp)) expected_cmds.insert(expected_cmds.size(), resp);
    if (cmd == CMD_GOAL) begin
      last_goal_x = px;
      last_goal_y = py;
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_cmds.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GOAL_TOL:   tol_r = val & 32'h7FFF_FFFF;
      CFG_MAX_LIN:    max_lin_r = val & 32'h7F_FFFF;
      CFG_MAX_TURN:   max_turn_r = val & 32'h7F_FFFF;
      CFG_TURN_THR:   thr_r = val & 32'h7FFF;
      CFG_TURN_GAIN:  turn_gain_r = val & 32'hFFFF;
      CFG_STEER_GAIN: steer_gain_r = val & 32'hFFFF;
      CFG_SPEED_GAIN: speed_gain_r = val & 32'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [31:0] tol, input logic [31:0] mlin,
                           input logic [31:0] mturn, input logic [31:0] thr,
                           input logic [31:0] tg, input logic [31:0] sg,
                           input logic [31:0] vg);
    write_reg(CFG_GOAL_TOL, tol);
    write_reg(CFG_MAX_LIN, mlin);
    write_reg(CFG_MAX_TURN, mturn);
    write_reg(CFG_TURN_THR, thr);
    write_reg(CFG_TURN_GAIN, tg);
    write_reg(CFG_STEER_GAIN, sg);
    write_reg(CFG_SPEED_GAIN, vg);
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
  endfunction

  function automatic logic signed [31:0] near(input logic signed [31:0] c);
    if ($urandom_range(0, 3) == 0)
      return c + $signed($urandom_range(0, 16384)) - 8192;
    return c + $signed($urandom_range(0, 6 * 65536)) - 3 * 65536;
  endfunction

  function automatic logic signed [15:0] rand_heading();
    return $signed(16'($urandom_range(0, 51472))) - 16'sd25736;
  endfunction

  // a goal followed by ticks, mostly around it and some stray
  task automatic random_traffic(input int n);
    int k;
    k = 0;
    while (k < n) begin
      send_req(CMD_GOAL, rand_coord(), rand_coord(), 16'($urandom));
      k++;
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 9) == 0)
          send_req(CMD_TICK, $urandom, $urandom, rand_heading());
        else
          send_req(CMD_TICK, near(last_goal_x), near(last_goal_y), rand_heading());
        k++;
      end
    end
  endtask

  task automatic random_config();
    write_all($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536),
              $urandom_range(0, 8388607), $urandom_range(0, 8388607),
              $urandom_range(0, 25736), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  task automatic test_directed();
    send_req(CMD_TICK, 32'sd100, -32'sd100, 16'sd0);            // no goal yet
    send_req(CMD_GOAL, 32'sd0, 32'sd0, 16'sh7FFF);              // heading ignored
    send_req(CMD_TICK, 32'sd0, 32'sd0, 16'sd0);                 // arrival
    send_req(CMD_TICK, 32'sd0, 32'sd0, 16'sd0);                 // goal gone
    send_req(CMD_GOAL, 32'sd196608, 32'sd0, 16'sd0);
    send_req(CMD_TICK, 32'sd0, 32'sd0, 16'sd0);                 // drive straight
    send_req(CMD_TICK, 32'sd0, 32'sd0, 16'sd25736);             // turn in place
    send_req(CMD_TICK, 32'sd0, 32'sd0, -16'sd25736);
    send_req(CMD_TICK, 32'sd0, 32'sd30000, 16'sd300);           // steer while driving
    send_req(CMD_GOAL, 32'sh8000_0000, 32'sh8000_0000, 16'sd0);
    send_req(CMD_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd25736);
    send_req(CMD_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000, -16'sd25736);
    send_req(CMD_GOAL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd0);
    send_req(CMD_TICK, 32'sh8000_0000, 32'sh8000_0000, -16'sd25736);
    send_req(CMD_TICK, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd12868);
    send_req(CMD_GOAL, -32'sd65536, 32'sd1, 16'sd0);            // bearing near +pi
    send_req(CMD_TICK, 32'sd0, 32'sd0, -16'sd25000);
    send_req(CMD_GOAL, -32'sd65536, -32'sd1, 16'sd0);           // bearing near -pi
    send_req(CMD_TICK, 32'sd0, 32'sd0, 16'sd25000);
    send_req(CMD_TICK, -32'sd60000, 32'sd0, 16'sd0);            // inside tolerance
    drain();
  endtask

  task automatic test_config_extremes();
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd25736,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, 32'h1234_5678);
    random_traffic(40);
    drain();
    write_all(32'd0, 32'd8388607, 32'd8388607, 32'd0, 32'd65535, 32'd65535, 32'd65535);
    send_req(CMD_GOAL, 32'sd5000, -32'sd5000, 16'sd0);
    send_req(CMD_TICK, 32'sd5000, -32'sd5000, 16'sd100);        // on goal, zero tolerance
    random_traffic(40);
    drain();
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_traffic(30);
    drain();
  endtask

  task automatic test_random_idling();
    random_config();
    send_idle_pct = 12; recv_idle_pct = 84;
    random_traffic(380);
    drain();
    random_config();
    send_idle_pct = 84; recv_idle_pct = 12;
    random_traffic(380);
    drain();
  endtask

  task automatic test_backpressure();
    write_all(32'd9830, 32'd32768, 32'd65536, 32'd2458, 32'd12288, 32'd8192, 32'd3277);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_left = 600;
    random_traffic(380);
    drain();
  endtask

  // receiver: long hold-off when requested, else random stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    ggc_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected result %p", out_data);
        fail_count++;
      end else begin
        exp_r = expected_cmds.pop_front();
        if (out_data.linear_speed !== exp_r.linear_speed) begin
          $error("linear_speed exp %0d got %0d", exp_r.linear_speed, out_data.linear_speed);
          fail_count++;
        end
        if (out_data.turn_rate !== exp_r.turn_rate) begin
          $error("turn_rate exp %0d got %0d", exp_r.turn_rate, out_data.turn_rate);
          fail_count++;
        end
        if (out_data.arrived !== exp_r.arrived) begin
          $error("arrived exp %0b got %0b", exp_r.arrived, out_data.arrived);
          fail_count++;
        end
        if (out_data.goal_active !== exp_r.goal_active) begin
          $error("goal_active exp %0b got %0b", exp_r.goal_active, out_data.goal_active);
          fail_count++;
        end
      end
    end
  end

  initial begin
    tol_r = 9830; max_lin_r = 32768; max_turn_r = 65536; thr_r = 2458;
    turn_gain_r = 12288; steer_gain_r = 8192; speed_gain_r = 3277;
    goal_held = 1'b0; goal_x_r = 0; goal_y_r = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_extremes();
    test_random_idling();
    test_backpressure();
    if (expected_cmds.size() != 0) begin
      $error("%0d results never arrived", expected_cmds.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
